FILE: rtl/core/key_autorepeat_double_press_macros.svh
`ifndef KEY_AUTOREPEAT_DOUBLE_PRESS_MACROS_SVH
`define KEY_AUTOREPEAT_DOUBLE_PRESS_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define KADP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kadp assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define KADP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kadp assertion failed");

`endif

FILE: rtl/core/kadp_pkg.sv
package kadp_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned CfgW  = 16;
	localparam int unsigned IdxW  = 2;

	localparam logic [CfgW-1:0] InitialDelayRst   = 16'd500;
	localparam logic [CfgW-1:0] RepeatIntervalRst = 16'd50;
	localparam logic [CfgW-1:0] DoubleWindowRst   = 16'd300;

	typedef enum logic [IdxW-1:0] {
		REG_INITIAL_DELAY   = 2'd0,
		REG_REPEAT_INTERVAL = 2'd1,
		REG_DOUBLE_WINDOW   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CfgW-1:0] initial_delay;
		logic [CfgW-1:0] repeat_interval;
		logic [CfgW-1:0] double_window;
	} cfg_t;

	typedef struct packed {
		logic pressed;
		logic double_pressed;
	} res_t;

endpackage

FILE: rtl/core/kadp_cfg.sv
module kadp_cfg
	import kadp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [IdxW-1:0] cfg_index,
	input  logic [CfgW-1:0] cfg_wdata,
	output cfg_t            cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.initial_delay   <= InitialDelayRst;
			cfg_q.repeat_interval <= RepeatIntervalRst;
			cfg_q.double_window   <= DoubleWindowRst;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_INITIAL_DELAY:   cfg_q.initial_delay   <= cfg_wdata;
				REG_REPEAT_INTERVAL: cfg_q.repeat_interval <= cfg_wdata;
				REG_DOUBLE_WINDOW:   cfg_q.double_window   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/kadp_eval.sv
module kadp_eval
	import kadp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             fire,
	input  logic             key_down,
	input  logic [TimeW-1:0] now_ms,
	output res_t             res
);

`include "key_autorepeat_double_press_macros.svh"

	logic             was_down_q;
	logic             held_q;
	logic             awaiting_q;
	logic [TimeW-1:0] last_event_q;
	logic [TimeW-1:0] last_tap_q;
	logic             tap_valid_q;

	logic             rising;
	logic [TimeW-1:0] elapsed;
	logic [TimeW-1:0] limit;
	logic             repeat_due;
	logic [TimeW-1:0] tap_gap;
	logic             dbl_hit;

	assign rising     = key_down && !was_down_q;
	assign elapsed    = now_ms - last_event_q;
	assign limit      = {{(TimeW-CfgW){1'b0}},
		(awaiting_q ? cfg.initial_delay : cfg.repeat_interval)};
	assign repeat_due = key_down && !rising && held_q && (elapsed >= limit);
	assign tap_gap    = now_ms - last_tap_q;
	assign dbl_hit    = rising && tap_valid_q &&
		(tap_gap <= {{(TimeW-CfgW){1'b0}}, cfg.double_window});

	assign res.pressed        = rising || repeat_due;
	assign res.double_pressed = dbl_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_down_q   <= 1'b0;
			held_q       <= 1'b0;
			awaiting_q   <= 1'b1;
			last_event_q <= '0;
			last_tap_q   <= '0;
			tap_valid_q  <= 1'b0;
		end else if (fire) begin
			was_down_q <= key_down;
			priority if (!key_down) begin
				held_q       <= 1'b0;
				awaiting_q   <= 1'b1;
				last_event_q <= '0;
			end else if (rising) begin
				held_q       <= 1'b1;
				awaiting_q   <= 1'b1;
				last_event_q <= now_ms;
			end else if (repeat_due) begin
				awaiting_q   <= 1'b0;
				last_event_q <= now_ms;
			end else begin
				held_q <= held_q;
			end
			if (dbl_hit) begin
				tap_valid_q <= 1'b0;
				last_tap_q  <= '0;
			end else if (rising) begin
				tap_valid_q <= 1'b1;
				last_tap_q  <= now_ms;
			end
		end
	end

	`KADP_ASSERT_NOW(a_held_implies_down, held_q, was_down_q)
	`KADP_ASSERT_NOW(a_dbl_only_on_rising, fire && res.double_pressed, res.pressed && rising)

endmodule

FILE: rtl/core/key_autorepeat_double_press.sv
// Typematic repeat and double-press detection for one polled key.
// Input channel (in_valid/in_ready) carries one word per poll: key_down,
// the sampled key level, and now_ms, a free-running wrapping ms timestamp.
// Output channel (out_valid/out_ready) returns exactly one word per poll:
// pressed (rising edge or repeat) and double_pressed.
// A poll accepted into the input register is evaluated against the key state
// and moves into the result register once that register is empty or its word
// is being taken; out_valid shows that the result register holds a word.
// One poll is accepted every cycle while results are taken; the rate is set
// by the 32-bit subtract and compare that updates the key state.
// When out_ready is low the result register holds; one more poll can wait
// in the input register, after which in_ready drops until the result is
// taken. cfg_we writes initial_delay (index 0), repeat_interval (1) and
// double_window (2) from cfg_wdata; other indexes are ignored. Write only
// while no poll is in flight.
// Reset clears both pipeline stages and the key state and loads the
// defaults 500, 50 and 300 ms; the block accepts polls right after reset.
module key_autorepeat_double_press
	import kadp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IdxW-1:0]  cfg_index,
	input  logic [CfgW-1:0]  cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             key_down,
	input  logic [TimeW-1:0] now_ms,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             pressed,
	output logic             double_pressed
);

`include "key_autorepeat_double_press_macros.svh"

	cfg_t             cfg;
	res_t             res;
	logic             valid_s1;
	logic             key_down_s1;
	logic [TimeW-1:0] now_ms_s1;
	logic             valid_s2;
	res_t             res_s2;
	logic             advance;

	kadp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	kadp_eval u_eval (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.fire     (advance),
		.key_down (key_down_s1),
		.now_ms   (now_ms_s1),
		.res      (res)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			key_down_s1 <= key_down;
			now_ms_s1   <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign pressed        = res_s2.pressed;
	assign double_pressed = res_s2.double_pressed;

	`KADP_ASSERT_NOW(a_dbl_needs_press, valid_s2 && res_s2.double_pressed, res_s2.pressed)
	`KADP_ASSERT_NOW(a_stall_only_when_full, !in_ready, valid_s1 && valid_s2 && !out_ready)
	`KADP_ASSERT_NEXT(a_advance_fills_out, advance, valid_s2)

endmodule
